/* rtl/core/bcsf_pkg.sv */
// Shared types and constants for the bitmap character scanout block.
package bcsf_pkg;

  localparam int ADDR_BITS   = 13;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int PIX_W       = 8;
  localparam int COLOR_W     = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int PIDX_W      = $clog2(PIX_W);

  localparam logic [1:0] CMD_WR_PIXEL = 2'd0;
  localparam logic [1:0] CMD_WR_COLOR = 2'd1;
  localparam logic [1:0] CMD_RENDER   = 2'd2;

  localparam logic [PIDX_W-1:0] PIX_LAST = PIDX_W'(PIX_W - 1);

  typedef struct packed {
    logic [PIX_W-1:0]   data;
    logic [COLOR_W-1:0] fore;
    logic               flip;
    logic               eol;
  } char_job_t;

endpackage

/* rtl/core/bcsf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bcsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bcsf_front.sv */
// Front end: accepts commands, writes the stores, reads them for renders and queues jobs.
module bcsf_front
  import bcsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [ADDR_BITS-1:0] in_write_address,
  input  logic [7:0]           in_write_data,
  input  logic [13:0]          in_char_address,
  input  logic [2:0]           in_raster_line,
  input  logic                 in_row_last_char,
  input  logic                 flip,
  input  logic [QCNT_W-1:0]    q_count,
  output logic                 push,
  output char_job_t            push_job
);

  logic                 accept;
  logic                 pix_we;
  logic                 col_we;
  logic [ADDR_BITS-1:0] raddr;
  logic [PIX_W-1:0]     pix_rdata;
  logic [COLOR_W-1:0]   col_rdata;
  logic                 pend_r;
  logic                 pend_nxt;
  logic                 flip_r;
  logic                 eol_r;
  logic [QCNT_W:0]      fill;

  assign fill   = {1'b0, q_count} + {{QCNT_W{1'b0}}, pend_r};
  assign busy   = fill >= (QCNT_W + 1)'(QDEPTH);
  assign accept = start && !busy;

  assign pix_we   = accept && (in_command == CMD_WR_PIXEL);
  assign col_we   = accept && (in_command == CMD_WR_COLOR);
  assign pend_nxt = accept && (in_command == CMD_RENDER);

  assign raddr = {in_char_address[9:5], in_raster_line, in_char_address[4:0]}
               ^ {ADDR_BITS{flip}};

  bcsf_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (in_write_address),
    .wdata (in_write_data),
    .raddr (raddr),
    .rdata (pix_rdata)
  );

  bcsf_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (in_write_address),
    .wdata (in_write_data[7:5]),
    .raddr (raddr),
    .rdata (col_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_nxt) begin
      flip_r <= flip;
      eol_r  <= in_row_last_char;
    end
  end

  assign push          = pend_r;
  assign push_job.data = pix_rdata;
  assign push_job.fore = col_rdata;
  assign push_job.flip = flip_r;
  assign push_job.eol  = eol_r;

endmodule

/* rtl/core/bcsf_queue.sv */
// Short job queue between the front end and the pixel serializer.
module bcsf_queue
  import bcsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  char_job_t         push_job,
  input  logic              pop,
  output logic              q_valid,
  output char_job_t         q_job,
  output logic [QCNT_W-1:0] q_count
);

  char_job_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_pop;

  assign do_pop  = pop && (cnt_r != '0);
  assign cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  assign q_valid = cnt_r != '0;
  assign q_job   = slot_r[rptr_r];
  assign q_count = cnt_r;

endmodule

/* rtl/core/bcsf_back.sv */
// Back end: shifts one queued character out as eight pixel transfers.
module bcsf_back
  import bcsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  char_job_t          q_job,
  output logic               pop,
  output logic               out_valid,
  output logic [COLOR_W-1:0] out_color_index,
  output logic [PIDX_W-1:0]  out_pixel_index,
  output logic               out_last_pixel,
  output logic               out_end_of_line
);

  logic              active_r;
  logic [PIDX_W-1:0] cnt_r;
  char_job_t         job_r;
  logic              load;
  logic              last;
  logic              bit_val;

  assign last = cnt_r == PIX_LAST;
  assign load = q_valid && (!active_r || last);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (load) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      active_r <= !last;
      cnt_r    <= cnt_r + PIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

  assign bit_val = job_r.flip ? job_r.data[cnt_r] : job_r.data[PIX_LAST - cnt_r];

  assign out_valid       = active_r;
  assign out_color_index = bit_val ? job_r.fore : '0;
  assign out_pixel_index = cnt_r;
  assign out_last_pixel  = last;
  assign out_end_of_line = last && job_r.eol;

endmodule

/* rtl/core/bitmap_char_scanout_with_flip.sv */
// Top level of the bitmap character scanout block with screen flip.
// A render's store data and pending flag are registered, then the job is queued,
// then the serializer loads it and raises out_valid. Writes are stored on accept.
// Renders are paced by the one-pixel-per-cycle serializer, which takes a new job
// on its last pixel; writes transfer every cycle while the two-entry queue has room.
// Reset clears control state and flip_screen; the stores hold garbage until written.
module bitmap_char_scanout_with_flip
  import bcsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [ADDR_BITS-1:0] in_write_address,
  input  logic [7:0]           in_write_data,
  input  logic [13:0]          in_char_address,
  input  logic [2:0]           in_raster_line,
  input  logic                 in_row_last_char,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_flip_screen,
  output logic                 out_valid,
  output logic [2:0]           out_color_index,
  output logic [2:0]           out_pixel_index,
  output logic                 out_last_pixel,
  output logic                 out_end_of_line
);

  logic              flip_r;
  logic              push;
  char_job_t         push_job;
  logic              pop;
  logic              q_valid;
  char_job_t         q_job;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      flip_r <= cfg_flip_screen;
    end
  end

  bcsf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .in_char_address  (in_char_address),
    .in_raster_line   (in_raster_line),
    .in_row_last_char (in_row_last_char),
    .flip             (flip_r),
    .q_count          (q_count),
    .push             (push),
    .push_job         (push_job)
  );

  bcsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_count  (q_count)
  );

  bcsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_color_index (out_color_index),
    .out_pixel_index (out_pixel_index),
    .out_last_pixel  (out_last_pixel),
    .out_end_of_line (out_end_of_line)
  );

`ifndef SYNTHESIS
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=>
      out_valid && (out_pixel_index == $past(out_pixel_index) + 3'd1))
    else $error("pixel run broken before its last pixel");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_pixel_index == 3'd0)
    else $error("pixel run started at nonzero index");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_count != QCNT_W'(QDEPTH))
    else $error("job queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_count != '0)
    else $error("job queue underflow");
`endif

endmodule
